// ===== rtl/core/ttr_pkg.sv =====
// Shared constants and width helpers for the triangle tile rasterizer.
// No dependencies; ttr_out_if, ttr_setup, ttr_scan and the top level refer to this package.
package ttr_pkg;

    localparam int unsigned EDGE_COUNT  = 3;
    localparam int unsigned QUEUE_DEPTH = 2;

    function automatic int unsigned weight_bits(input int unsigned coord_bits);
        return 2 * coord_bits + 2;
    endfunction

    function automatic int unsigned count_bits(input int unsigned tile_size);
        return $clog2(tile_size + 1);
    endfunction

    function automatic int unsigned entry_bits(input int unsigned coord_bits,
                                               input int unsigned tile_size);
        return 2 * coord_bits + 2 * count_bits(tile_size)
            + EDGE_COUNT * (weight_bits(coord_bits) + 2 * (coord_bits + 1));
    endfunction

endpackage

// ===== rtl/core/ttr_in_if.sv =====
// Input channel of the rasterizer: one triangle and its tile box per transaction.
// Depends on nothing but its COORD_BITS parameter.
interface ttr_in_if #(parameter int unsigned COORD_BITS = 12);

    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] vertex0_x;
    logic [COORD_BITS-1:0] vertex0_y;
    logic [COORD_BITS-1:0] vertex1_x;
    logic [COORD_BITS-1:0] vertex1_y;
    logic [COORD_BITS-1:0] vertex2_x;
    logic [COORD_BITS-1:0] vertex2_y;
    logic [COORD_BITS-1:0] tile_left;
    logic [COORD_BITS-1:0] tile_right;
    logic [COORD_BITS-1:0] tile_top;
    logic [COORD_BITS-1:0] tile_bottom;

    modport source (
        output valid, vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x, vertex2_y,
        output tile_left, tile_right, tile_top, tile_bottom,
        input  ready
    );

    modport sink (
        input  valid, vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x, vertex2_y,
        input  tile_left, tile_right, tile_top, tile_bottom,
        output ready
    );

endinterface

// ===== rtl/core/ttr_out_if.sv =====
// Output channel of the rasterizer: one covered pixel or the empty marker per transaction.
// Depends on ttr_pkg for the weight width.
interface ttr_out_if #(parameter int unsigned COORD_BITS = 12);

    localparam int unsigned WEIGHT_BITS = ttr_pkg::weight_bits(COORD_BITS);

    logic                          valid;
    logic                          ready;
    logic [COORD_BITS-1:0]         pixel_x;
    logic [COORD_BITS-1:0]         pixel_y;
    logic signed [WEIGHT_BITS-1:0] weight_a;
    logic signed [WEIGHT_BITS-1:0] weight_b;
    logic signed [WEIGHT_BITS-1:0] weight_c;
    logic                          covered;
    logic                          last;

    modport source (
        output valid, pixel_x, pixel_y, weight_a, weight_b, weight_c, covered, last,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, weight_a, weight_b, weight_c, covered, last,
        output ready
    );

endinterface

// ===== rtl/core/ttr_setup.sv =====
// Front end: accepts a triangle, clips its bounding box to the tile and sets up
// the edge function of each edge. Depends on ttr_pkg and ttr_in_if.
module ttr_setup #(
    parameter int unsigned COORD_BITS = 12,
    parameter int unsigned TILE_SIZE  = 8
) (
    input  logic clk,
    input  logic rst_n,
    ttr_in_if.sink in_ch,
    output logic push_valid,
    input  logic push_ready,
    output logic [ttr_pkg::entry_bits(COORD_BITS, TILE_SIZE)-1:0] push_data
);

    localparam int unsigned CB    = COORD_BITS;
    localparam int unsigned WB    = ttr_pkg::weight_bits(COORD_BITS);
    localparam int unsigned CNT_W = ttr_pkg::count_bits(TILE_SIZE);
    localparam int unsigned EC    = ttr_pkg::EDGE_COUNT;
    localparam int EDGE_START [EC] = '{1, 2, 0};
    localparam int EDGE_END   [EC] = '{2, 0, 1};

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BOX  = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_PUSH = 2'd3;

    typedef struct packed {
        logic [CB-1:0]            x0;
        logic [CB-1:0]            y0;
        logic [CNT_W-1:0]         w;
        logic [CNT_W-1:0]         h;
        logic [EC-1:0][WB-1:0]    init;
        logic [EC-1:0][CB:0]      dx;
        logic [EC-1:0][CB:0]      dy;
    } setup_t;

    logic [1:0]              state_reg;
    logic [1:0]              state_next;
    logic [CB-1:0]           vx_reg [EC];
    logic [CB-1:0]           vy_reg [EC];
    logic [CB-1:0]           tile_left_reg;
    logic [CB-1:0]           tile_right_reg;
    logic [CB-1:0]           tile_top_reg;
    logic [CB-1:0]           tile_bottom_reg;
    logic [CB-1:0]           x0_reg;
    logic [CB-1:0]           x0_next;
    logic [CB-1:0]           y0_reg;
    logic [CB-1:0]           y0_next;
    logic [CB-1:0]           x1_box;
    logic [CB-1:0]           y1_box;
    logic [CB-1:0]           span_x;
    logic [CB-1:0]           span_y;
    logic [CNT_W-1:0]        w_reg;
    logic [CNT_W-1:0]        w_next;
    logic [CNT_W-1:0]        h_reg;
    logic [CNT_W-1:0]        h_next;
    logic signed [CB:0]      dx_reg [EC];
    logic signed [CB:0]      dx_next [EC];
    logic signed [CB:0]      dy_reg [EC];
    logic signed [CB:0]      dy_next [EC];
    logic signed [CB:0]      ox_reg [EC];
    logic signed [CB:0]      ox_next [EC];
    logic signed [CB:0]      oy_reg [EC];
    logic signed [CB:0]      oy_next [EC];
    logic signed [WB-1:0]    pa_reg [EC];
    logic signed [WB-1:0]    pa_next [EC];
    logic signed [WB-1:0]    pb_reg [EC];
    logic signed [WB-1:0]    pb_next [EC];
    setup_t                  entry;
    logic                    accept;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign push_valid  = (state_reg == S_PUSH);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = S_BOX;
                end
            end
            S_BOX:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Bounding box clipped to the tile, with the span cut to the tile size.
    always_comb
    begin
        x0_next = vx_reg[0];
        x1_box  = vx_reg[0];
        y0_next = vy_reg[0];
        y1_box  = vy_reg[0];
        for (int k = 1; k < EC; k++)
        begin
            if (vx_reg[k] < x0_next) x0_next = vx_reg[k];
            if (vx_reg[k] > x1_box)  x1_box  = vx_reg[k];
            if (vy_reg[k] < y0_next) y0_next = vy_reg[k];
            if (vy_reg[k] > y1_box)  y1_box  = vy_reg[k];
        end
        if (tile_left_reg > x0_next)   x0_next = tile_left_reg;
        if (tile_right_reg < x1_box)   x1_box  = tile_right_reg;
        if (tile_top_reg > y0_next)    y0_next = tile_top_reg;
        if (tile_bottom_reg < y1_box)  y1_box  = tile_bottom_reg;
        span_x = x1_box - x0_next;
        span_y = y1_box - y0_next;
        w_next = '0;
        h_next = '0;
        if (x1_box > x0_next)
        begin
            w_next = (span_x > CB'(TILE_SIZE)) ? CNT_W'(TILE_SIZE) : CNT_W'(span_x);
        end
        if (y1_box > y0_next)
        begin
            h_next = (span_y > CB'(TILE_SIZE)) ? CNT_W'(TILE_SIZE) : CNT_W'(span_y);
        end
    end

    always_comb
    begin
        for (int k = 0; k < EC; k++)
        begin
            dx_next[k] = $signed({1'b0, vx_reg[EDGE_END[k]]})
                       - $signed({1'b0, vx_reg[EDGE_START[k]]});
            dy_next[k] = $signed({1'b0, vy_reg[EDGE_END[k]]})
                       - $signed({1'b0, vy_reg[EDGE_START[k]]});
            ox_next[k] = $signed({1'b0, x0_next}) - $signed({1'b0, vx_reg[EDGE_START[k]]});
            oy_next[k] = $signed({1'b0, y0_next}) - $signed({1'b0, vy_reg[EDGE_START[k]]});
            pa_next[k] = WB'(dx_reg[k]) * WB'(oy_reg[k]);
            pb_next[k] = WB'(dy_reg[k]) * WB'(ox_reg[k]);
        end
    end

    always_comb
    begin
        entry.x0 = x0_reg;
        entry.y0 = y0_reg;
        entry.w  = w_reg;
        entry.h  = h_reg;
        for (int k = 0; k < EC; k++)
        begin
            entry.init[k] = pa_reg[k] - pb_reg[k];
            entry.dx[k]   = dx_reg[k];
            entry.dy[k]   = dy_reg[k];
        end
    end

    assign push_data = entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            vx_reg[0]       <= in_ch.vertex0_x;
            vy_reg[0]       <= in_ch.vertex0_y;
            vx_reg[1]       <= in_ch.vertex1_x;
            vy_reg[1]       <= in_ch.vertex1_y;
            vx_reg[2]       <= in_ch.vertex2_x;
            vy_reg[2]       <= in_ch.vertex2_y;
            tile_left_reg   <= in_ch.tile_left;
            tile_right_reg  <= in_ch.tile_right;
            tile_top_reg    <= in_ch.tile_top;
            tile_bottom_reg <= in_ch.tile_bottom;
        end
        if (state_reg == S_BOX)
        begin
            x0_reg <= x0_next;
            y0_reg <= y0_next;
            w_reg  <= w_next;
            h_reg  <= h_next;
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            ox_reg <= ox_next;
            oy_reg <= oy_next;
        end
        if (state_reg == S_MUL)
        begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
        end
    end

endmodule

// ===== rtl/core/ttr_queue.sv =====
// Small first-in first-out queue that decouples the setup front end from the scan.
// Self-contained; the entry width and depth come from its parameters.
module ttr_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]   mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != COUNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/ttr_scan.sv =====
// Back end: steps the edge functions over the clipped box one pixel per cycle unless the output stalls,
// and delivers covered pixels or the empty marker through an output register. Depends on ttr_pkg and ttr_out_if.
module ttr_scan #(
    parameter int unsigned COORD_BITS = 12,
    parameter int unsigned TILE_SIZE  = 8
) (
    input  logic clk,
    input  logic rst_n,
    input  logic pop_valid,
    output logic pop_ready,
    input  logic [ttr_pkg::entry_bits(COORD_BITS, TILE_SIZE)-1:0] pop_data,
    ttr_out_if.source out_ch
);

    localparam int unsigned CB    = COORD_BITS;
    localparam int unsigned WB    = ttr_pkg::weight_bits(COORD_BITS);
    localparam int unsigned CNT_W = ttr_pkg::count_bits(TILE_SIZE);
    localparam int unsigned EC    = ttr_pkg::EDGE_COUNT;

    localparam logic [1:0] B_IDLE  = 2'd0;
    localparam logic [1:0] B_SCAN  = 2'd1;
    localparam logic [1:0] B_FLUSH = 2'd2;

    typedef struct packed {
        logic [CB-1:0]            x0;
        logic [CB-1:0]            y0;
        logic [CNT_W-1:0]         w;
        logic [CNT_W-1:0]         h;
        logic [EC-1:0][WB-1:0]    init;
        logic [EC-1:0][CB:0]      dx;
        logic [EC-1:0][CB:0]      dy;
    } setup_t;

    setup_t               entry;
    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [CB-1:0]        x0_reg;
    logic [CB-1:0]        x0_next;
    logic [CB-1:0]        cur_x_reg;
    logic [CB-1:0]        cur_x_next;
    logic [CB-1:0]        cur_y_reg;
    logic [CB-1:0]        cur_y_next;
    logic [CNT_W-1:0]     col_reg;
    logic [CNT_W-1:0]     col_next;
    logic [CNT_W-1:0]     row_reg;
    logic [CNT_W-1:0]     row_next;
    logic [CNT_W-1:0]     w_reg;
    logic [CNT_W-1:0]     w_next;
    logic [CNT_W-1:0]     h_reg;
    logic [CNT_W-1:0]     h_next;
    logic signed [WB-1:0] e_reg [EC];
    logic signed [WB-1:0] e_next [EC];
    logic signed [WB-1:0] r_reg [EC];
    logic signed [WB-1:0] r_next [EC];
    logic signed [WB-1:0] dx_reg [EC];
    logic signed [WB-1:0] dx_next [EC];
    logic signed [WB-1:0] dy_reg [EC];
    logic signed [WB-1:0] dy_next [EC];
    logic                 pend_valid_reg;
    logic                 pend_valid_next;
    logic [CB-1:0]        pend_x_reg;
    logic [CB-1:0]        pend_x_next;
    logic [CB-1:0]        pend_y_reg;
    logic [CB-1:0]        pend_y_next;
    logic signed [WB-1:0] pend_w_reg [EC];
    logic signed [WB-1:0] pend_w_next [EC];
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [CB-1:0]        out_x_reg;
    logic [CB-1:0]        out_x_next;
    logic [CB-1:0]        out_y_reg;
    logic [CB-1:0]        out_y_next;
    logic signed [WB-1:0] out_w_reg [EC];
    logic signed [WB-1:0] out_w_next [EC];
    logic                 out_covered_reg;
    logic                 out_covered_next;
    logic                 out_last_reg;
    logic                 out_last_next;
    logic                 covered;
    logic                 out_free;
    logic                 advance;
    logic                 load_out;
    logic                 col_done;
    logic                 row_done;

    assign entry     = pop_data;
    assign pop_ready = (state_reg == B_IDLE);
    assign covered   = !e_reg[0][WB-1] && !e_reg[1][WB-1] && !e_reg[2][WB-1];
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign advance   = !(covered && pend_valid_reg) || out_free;
    assign col_done  = (col_reg + CNT_W'(1) == w_reg);
    assign row_done  = (row_reg + CNT_W'(1) == h_reg);

    // A covered pixel is held back in the pending register so that the final one can carry last.
    always_comb
    begin
        state_next       = state_reg;
        x0_next          = x0_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        w_next           = w_reg;
        h_next           = h_reg;
        e_next           = e_reg;
        r_next           = r_reg;
        dx_next          = dx_reg;
        dy_next          = dy_reg;
        pend_valid_next  = pend_valid_reg;
        pend_x_next      = pend_x_reg;
        pend_y_next      = pend_y_reg;
        pend_w_next      = pend_w_reg;
        out_valid_next   = out_valid_reg && !out_ch.ready;
        out_x_next       = out_x_reg;
        out_y_next       = out_y_reg;
        out_w_next       = out_w_reg;
        out_covered_next = out_covered_reg;
        out_last_next    = out_last_reg;
        load_out         = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    x0_next    = entry.x0;
                    cur_x_next = entry.x0;
                    cur_y_next = entry.y0;
                    col_next   = '0;
                    row_next   = '0;
                    w_next     = entry.w;
                    h_next     = entry.h;
                    for (int k = 0; k < EC; k++)
                    begin
                        e_next[k]  = $signed(entry.init[k]);
                        r_next[k]  = $signed(entry.init[k]);
                        dx_next[k] = WB'($signed(entry.dx[k]));
                        dy_next[k] = WB'($signed(entry.dy[k]));
                    end
                    state_next = (entry.w == '0 || entry.h == '0) ? B_FLUSH : B_SCAN;
                end
            end
            B_SCAN:
            begin
                if (advance)
                begin
                    if (covered)
                    begin
                        if (pend_valid_reg)
                        begin
                            load_out         = 1'b1;
                            out_valid_next   = 1'b1;
                            out_x_next       = pend_x_reg;
                            out_y_next       = pend_y_reg;
                            out_w_next       = pend_w_reg;
                            out_covered_next = 1'b1;
                            out_last_next    = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_x_next     = cur_x_reg;
                        pend_y_next     = cur_y_reg;
                        pend_w_next     = e_reg;
                    end
                    if (col_done)
                    begin
                        if (row_done)
                        begin
                            state_next = B_FLUSH;
                        end
                        else
                        begin
                            col_next   = '0;
                            row_next   = row_reg + CNT_W'(1);
                            cur_x_next = x0_reg;
                            cur_y_next = cur_y_reg + CB'(1);
                            for (int k = 0; k < EC; k++)
                            begin
                                r_next[k] = r_reg[k] + dx_reg[k];
                                e_next[k] = r_reg[k] + dx_reg[k];
                            end
                        end
                    end
                    else
                    begin
                        col_next   = col_reg + CNT_W'(1);
                        cur_x_next = cur_x_reg + CB'(1);
                        for (int k = 0; k < EC; k++)
                        begin
                            e_next[k] = e_reg[k] - dy_reg[k];
                        end
                    end
                end
            end
            B_FLUSH:
            begin
                if (out_free)
                begin
                    load_out         = 1'b1;
                    out_valid_next   = 1'b1;
                    out_last_next    = 1'b1;
                    out_covered_next = pend_valid_reg;
                    out_x_next       = pend_valid_reg ? pend_x_reg : '0;
                    out_y_next       = pend_valid_reg ? pend_y_reg : '0;
                    for (int k = 0; k < EC; k++)
                    begin
                        out_w_next[k] = pend_valid_reg ? pend_w_reg[k] : '0;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x0_reg          <= x0_next;
        cur_x_reg       <= cur_x_next;
        cur_y_reg       <= cur_y_next;
        col_reg         <= col_next;
        row_reg         <= row_next;
        w_reg           <= w_next;
        h_reg           <= h_next;
        e_reg           <= e_next;
        r_reg           <= r_next;
        dx_reg          <= dx_next;
        dy_reg          <= dy_next;
        pend_x_reg      <= pend_x_next;
        pend_y_reg      <= pend_y_next;
        pend_w_reg      <= pend_w_next;
        out_x_reg       <= out_x_next;
        out_y_reg       <= out_y_next;
        out_w_reg       <= out_w_next;
        out_covered_reg <= out_covered_next;
        out_last_reg    <= out_last_next;
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.pixel_x  = out_x_reg;
    assign out_ch.pixel_y  = out_y_reg;
    assign out_ch.weight_a = out_w_reg[0];
    assign out_ch.weight_b = out_w_reg[1];
    assign out_ch.weight_c = out_w_reg[2];
    assign out_ch.covered  = out_covered_reg;
    assign out_ch.last     = out_last_reg;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> out_free)
        else $error("output register loaded while a transaction was still waiting");

    a_scan_emit_from_held: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && state_reg == B_SCAN |-> pend_valid_reg && covered)
        else $error("scan emitted a pixel without a held covered pixel");

    a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_covered_reg |-> out_last_reg)
        else $error("empty marker transaction without last");

    a_scan_in_box: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_SCAN |-> col_reg < w_reg && row_reg < h_reg)
        else $error("scan position outside the clipped box");
`endif

endmodule

// ===== rtl/core/triangle_tile_rasterizer.sv =====
// Top level of the triangle tile rasterizer: setup front end, queue and scan back end.
// Depends on ttr_pkg, ttr_in_if, ttr_out_if, ttr_setup, ttr_queue and ttr_scan.
//
// Each triangle transaction is clipped to its tile and scanned in row-major order over
// the clipped box of W by H pixels, both at most TILE_SIZE. The setup front end works
// through its box and multiply states and hands its result through a two-entry queue,
// so it works on the next triangle while the scan runs. For a box of two pixels or more
// the scan unit sets the rate: one pixel per cycle while the output is not stalled, plus
// taking the setup from the queue and delivering the final transaction. For an empty or
// one-pixel box the setup front end sets it. A covered pixel waits only while the
// output transaction before it is not yet taken.
module triangle_tile_rasterizer #(
    parameter int unsigned COORD_BITS = 12,
    parameter int unsigned TILE_SIZE  = 8
) (
    input  logic clk,
    input  logic rst_n,
    ttr_in_if.sink    in_ch,
    ttr_out_if.source out_ch
);

    localparam int unsigned ENTRY_W = ttr_pkg::entry_bits(COORD_BITS, TILE_SIZE);

    logic               push_valid;
    logic               push_ready;
    logic [ENTRY_W-1:0] push_data;
    logic               pop_valid;
    logic               pop_ready;
    logic [ENTRY_W-1:0] pop_data;

    ttr_setup #(
        .COORD_BITS (COORD_BITS),
        .TILE_SIZE  (TILE_SIZE)
    ) u_setup (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    ttr_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (ttr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    ttr_scan #(
        .COORD_BITS (COORD_BITS),
        .TILE_SIZE  (TILE_SIZE)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_ch    (out_ch)
    );

endmodule
